### design/cdqr_pkg.sv
// ============================================================================
// cdqr_pkg
// Shared types, constants and the answer-record byte table for the
// captive-portal DNS query responder.
// ============================================================================
package cdqr_pkg;

   localparam int BUFFER_BYTES_DEFAULT = 512;
   localparam int HEADER_LEN           = 12;
   localparam int RECORD_LEN           = 16;
   localparam int LABEL_SPAN           = 256;   // upper bound on the reach of one label byte

   localparam logic [7:0] HDR_QR_AA     = 8'h84;
   localparam logic [7:0] LABEL_PTR_MSK = 8'hC0;

   localparam logic [1:0] STATUS_ANSWER = 2'd0;
   localparam logic [1:0] STATUS_NODATA = 2'd1;
   localparam logic [1:0] STATUS_DROP   = 2'd2;

   typedef enum logic [2:0] {
      WALK_ACTIVE = 3'b001,
      WALK_ROOT   = 3'b010,
      WALK_BAD    = 3'b100
   } walk_type;

   // descriptor of one finished query, front to back
   typedef struct packed {
      logic drop;
      logic is_a;
      logic rd_bit;
      logic bank;
   } job_flags_type;

   // back tells front that a buffer bank may be refilled
   typedef struct packed {
      logic valid;
      logic bank;
   } release_type;

   // byte k of the appended A record: pointer to the question name,
   // type A, class IN, TTL 60, length 4, then the address octets
   function automatic logic [7:0] record_byte(input logic [3:0] k,
                                              input logic [31:0] addr);
      logic [7:0] r;
      unique case (k)
         4'd0:    r = 8'hC0;
         4'd1:    r = 8'h0C;
         4'd3:    r = 8'h01;
         4'd5:    r = 8'h01;
         4'd9:    r = 8'h3C;
         4'd11:   r = 8'h04;
         4'd12:   r = addr[31:24];
         4'd13:   r = addr[23:16];
         4'd14:   r = addr[15:8];
         4'd15:   r = addr[7:0];
         default: r = 8'h00;
      endcase
      return r;
   endfunction

endpackage

### design/cdqr_ram.sv
// ============================================================================
// cdqr_ram
// Generic single-write, single-read RAM with registered read data.
// ============================================================================
module cdqr_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### design/cdqr_front.sv
// ============================================================================
// cdqr_front
// Loads query bytes into the free buffer bank, walks the question name and
// classifies the query on its last byte.
// ============================================================================
module cdqr_front
   import cdqr_pkg::*;
#(
   parameter int BUFFER_BYTES = BUFFER_BYTES_DEFAULT,
   parameter int CNT_W        = $clog2(BUFFER_BYTES)
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_tvalid,
   output logic                req_tready,
   input  logic [7:0]          req_tdata,
   input  logic                req_tlast,
   output logic                ram_wr_en,
   output logic [CNT_W:0]      ram_wr_addr,
   output logic [7:0]          ram_wr_data,
   output logic                push,
   output job_flags_type       push_flags,
   output logic [CNT_W-1:0]    push_len,
   input  release_type         release_bank
);

   localparam int MAX_QUERY = BUFFER_BYTES - RECORD_LEN;
   localparam int NLP_W     = $clog2(BUFFER_BYTES + LABEL_SPAN);

   logic [CNT_W-1:0] count_ff, count_in;
   logic [NLP_W-1:0] nlp_ff, nlp_in;
   logic [CNT_W-1:0] end_ff, end_in;
   walk_type         walk_ff, walk_in;
   logic             over_ff, over_in;
   logic             rd_ff, rd_in;
   logic [7:0]       qhi_ff, qhi_in, qlo_ff, qlo_in;
   logic             bank_ff, bank_in;
   logic [1:0]       busy_ff, busy_in;

   logic accept, store, drop;
   logic [7:0] b;

   assign b          = req_tdata;
   assign req_tready = !busy_ff[bank_ff];
   assign accept     = req_tvalid && req_tready;
   assign store      = count_ff < CNT_W'(MAX_QUERY);

   assign ram_wr_en   = accept && store;
   assign ram_wr_addr = {bank_ff, count_ff};
   assign ram_wr_data = b;

   always_comb begin
      count_in = count_ff;
      nlp_in   = nlp_ff;
      end_in   = end_ff;
      walk_in  = walk_ff;
      over_in  = over_ff;
      rd_in    = rd_ff;
      qhi_in   = qhi_ff;
      qlo_in   = qlo_ff;
      if (accept) begin
         if (store) begin
            count_in = count_ff + CNT_W'(1);
            if (walk_ff == WALK_ACTIVE && NLP_W'(count_ff) == nlp_ff) begin
               if (b == 8'h00) begin
                  walk_in = WALK_ROOT;
                  end_in  = count_ff;
               end else if ((b & LABEL_PTR_MSK) != 8'h00) begin
                  walk_in = WALK_BAD;
               end else begin
                  nlp_in = NLP_W'(count_ff) + NLP_W'(b) + NLP_W'(1);
               end
            end
            if (count_ff == CNT_W'(2)) begin
               rd_in = b[0];
            end
            if (walk_ff == WALK_ROOT) begin
               if ({1'b0, count_ff} == {1'b0, end_ff} + (CNT_W+1)'(1)) begin
                  qhi_in = b;
               end
               if ({1'b0, count_ff} == {1'b0, end_ff} + (CNT_W+1)'(2)) begin
                  qlo_in = b;
               end
            end
         end else begin
            over_in = 1'b1;
         end
      end
   end

   // classification uses the state including the final byte
   assign drop = (count_in < CNT_W'(HEADER_LEN)) || over_in || (walk_in != WALK_ROOT) ||
                 ({1'b0, end_in} + (CNT_W+1)'(4) >= {1'b0, count_in});

   assign push             = accept && req_tlast;
   assign push_len         = count_in;
   assign push_flags.drop  = drop;
   assign push_flags.is_a  = ({qhi_in, qlo_in} == 16'h0001);
   assign push_flags.rd_bit = rd_in;
   assign push_flags.bank  = bank_ff;

   always_comb begin
      busy_in = busy_ff;
      bank_in = bank_ff;
      if (release_bank.valid) begin
         busy_in[release_bank.bank] = 1'b0;
      end
      if (push) begin
         busy_in[bank_ff] = 1'b1;
         bank_in          = !bank_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset || push) begin
         count_ff <= '0;
         nlp_ff   <= NLP_W'(HEADER_LEN);
         end_ff   <= '0;
         walk_ff  <= WALK_ACTIVE;
         over_ff  <= 1'b0;
      end else begin
         count_ff <= count_in;
         nlp_ff   <= nlp_in;
         end_ff   <= end_in;
         walk_ff  <= walk_in;
         over_ff  <= over_in;
      end
      if (reset) begin
         busy_ff <= '0;
         bank_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         bank_ff <= bank_in;
      end
      rd_ff  <= rd_in;
      qhi_ff <= qhi_in;
      qlo_ff <= qlo_in;
   end

endmodule

### design/cdqr_queue.sv
// ============================================================================
// cdqr_queue
// Two-entry descriptor queue between front and back, head visible.
// ============================================================================
module cdqr_queue
   import cdqr_pkg::*;
#(
   parameter int CNT_W = $clog2(BUFFER_BYTES_DEFAULT)
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  job_flags_type    push_flags,
   input  logic [CNT_W-1:0] push_len,
   input  logic             pop,
   output logic             head_valid,
   output job_flags_type    head_flags,
   output logic [CNT_W-1:0] head_len
);

   job_flags_type    flags_ff [2];
   logic [CNT_W-1:0] len_ff [2];
   logic             wr_ptr_ff, rd_ptr_ff;
   logic [1:0]       count_ff;

   assign head_valid = count_ff != 2'd0;
   assign head_flags = flags_ff[rd_ptr_ff];
   assign head_len   = len_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (push) begin
         flags_ff[wr_ptr_ff] <= push_flags;
         len_ff[wr_ptr_ff]   <= push_len;
      end
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         if (push) begin
            wr_ptr_ff <= !wr_ptr_ff;
         end
         if (pop) begin
            rd_ptr_ff <= !rd_ptr_ff;
         end
         count_ff <= count_ff + {1'b0, push} - {1'b0, pop};
      end
   end

endmodule

### design/cdqr_back.sv
// ============================================================================
// cdqr_back
// Replays a classified query byte by byte from its bank, rewrites the
// header, appends the A record to A answers and packs the reply into 8-byte items.
// ============================================================================
module cdqr_back
   import cdqr_pkg::*;
#(
   parameter int CNT_W = $clog2(BUFFER_BYTES_DEFAULT)
) (
   input  logic             clock,
   input  logic             reset,
   input  logic [31:0]      portal_address,
   input  logic             head_valid,
   input  job_flags_type    head_flags,
   input  logic [CNT_W-1:0] head_len,
   output logic             pop,
   output release_type      release_bank,
   output logic             ram_rd_en,
   output logic [CNT_W:0]   ram_rd_addr,
   input  logic [7:0]       ram_rd_data,
   output logic             rsp_tvalid,
   input  logic             rsp_tready,
   output logic [71:0]      rsp_tdata,
   output logic             rsp_tlast,
   output logic [1:0]       rsp_tuser
);

   // current job
   logic             job_valid_ff, job_valid_in;
   job_flags_type    job_ff;
   logic [CNT_W-1:0] job_len_ff, job_last_ff, idx_ff;
   // byte in flight (RAM read latency)
   logic       p_valid_ff, p_ram_ff, p_last_ff, p_empty_ff;
   logic [7:0] p_const_ff;
   logic [2:0] p_lane_ff;
   logic [1:0] p_status_ff;
   // word under assembly
   logic        acc_full_ff, acc_end_ff;
   logic [63:0] acc_word_ff;
   logic [3:0]  acc_cnt_ff;
   logic [1:0]  acc_status_ff;
   // output register
   logic        out_valid_ff, out_end_ff;
   logic [63:0] out_word_ff;
   logic [3:0]  out_cnt_ff;
   logic [1:0]  out_status_ff;

   logic move, p_take, issue, issue_last, use_ram, in_query;
   logic [7:0]  const_byte, p_byte;
   logic [63:0] base_word;
   logic [1:0]  job_status;

   assign move   = acc_full_ff && (!out_valid_ff || rsp_tready);
   assign p_take = p_valid_ff && (!acc_full_ff || move);
   assign issue  = job_valid_ff && (!p_valid_ff || p_take);
   assign issue_last = job_ff.drop || (idx_ff == job_last_ff);
   assign pop    = head_valid && (!job_valid_ff || (issue && issue_last));

   assign release_bank.valid = issue && issue_last;
   assign release_bank.bank  = job_ff.bank;

   assign job_status = job_ff.drop ? STATUS_DROP :
                       (job_ff.is_a ? STATUS_ANSWER : STATUS_NODATA);

   // header rewrite and record bytes are constants; the rest comes from RAM
   assign in_query = idx_ff < job_len_ff;
   always_comb begin
      use_ram    = 1'b0;
      const_byte = 8'h00;
      if (in_query) begin
         if (idx_ff == CNT_W'(2)) begin
            const_byte = HDR_QR_AA | {7'd0, job_ff.rd_bit};
         end else if (idx_ff == CNT_W'(7)) begin
            const_byte = {7'd0, job_ff.is_a};
         end else if (idx_ff == CNT_W'(3) || idx_ff == CNT_W'(6) ||
                      (idx_ff >= CNT_W'(8) && idx_ff < CNT_W'(HEADER_LEN))) begin
            const_byte = 8'h00;
         end else begin
            use_ram = 1'b1;
         end
      end else begin
         const_byte = record_byte(4'(idx_ff - job_len_ff), portal_address);
      end
   end

   assign ram_rd_en   = issue && !job_ff.drop && use_ram;
   assign ram_rd_addr = {job_ff.bank, idx_ff};

   assign p_byte    = p_ram_ff ? ram_rd_data : p_const_ff;
   assign base_word = (p_lane_ff == 3'd0) ? 64'd0 : acc_word_ff;

   always_comb begin
      job_valid_in = job_valid_ff;
      if (issue && issue_last) begin
         job_valid_in = 1'b0;
      end
      if (pop) begin
         job_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         job_valid_ff <= 1'b0;
         p_valid_ff   <= 1'b0;
         acc_full_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         job_valid_ff <= job_valid_in;
         if (issue) begin
            p_valid_ff <= 1'b1;
         end else if (p_take) begin
            p_valid_ff <= 1'b0;
         end
         if (p_take) begin
            acc_full_ff <= p_empty_ff || p_last_ff || (p_lane_ff == 3'd7);
         end else if (move) begin
            acc_full_ff <= 1'b0;
         end
         if (move) begin
            out_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            out_valid_ff <= 1'b0;
         end
      end

      if (pop) begin
         job_ff      <= head_flags;
         job_len_ff  <= head_len;
         job_last_ff <= head_len - CNT_W'(1) +
                        (head_flags.is_a ? CNT_W'(RECORD_LEN) : CNT_W'(0));
         idx_ff      <= '0;
      end else if (issue) begin
         idx_ff <= idx_ff + CNT_W'(1);
      end

      if (issue) begin
         p_ram_ff    <= use_ram && !job_ff.drop;
         p_const_ff  <= const_byte;
         p_lane_ff   <= idx_ff[2:0];
         p_last_ff   <= issue_last;
         p_empty_ff  <= job_ff.drop;
         p_status_ff <= job_status;
      end

      if (p_take) begin
         acc_end_ff    <= p_last_ff || p_empty_ff;
         acc_status_ff <= p_status_ff;
         if (p_empty_ff) begin
            acc_word_ff <= 64'd0;
            acc_cnt_ff  <= 4'd0;
         end else begin
            acc_word_ff <= base_word | (64'(p_byte) << {p_lane_ff, 3'b000});
            acc_cnt_ff  <= {1'b0, p_lane_ff} + 4'd1;
         end
      end

      if (move) begin
         out_word_ff   <= acc_word_ff;
         out_cnt_ff    <= acc_cnt_ff;
         out_end_ff    <= acc_end_ff;
         out_status_ff <= acc_status_ff;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {4'd0, out_cnt_ff, out_word_ff};
   assign rsp_tlast  = out_end_ff;
   assign rsp_tuser  = out_status_ff;

endmodule

### design/captive_dns_query_responder.sv
// ============================================================================
// captive_dns_query_responder
// Answers each well-formed DNS A query with the portal address (captive-portal DNS).
// ============================================================================
// Query payload bytes enter one per cycle on the req_ stream, the last one
// flagged by req_tlast. The front stores them in one of two buffer banks and
// walks the question name as they arrive; on the last byte it classifies the
// query and queues a descriptor, then switches to the other bank, so a new
// query loads while the previous one is replayed. It stalls (req_tready low)
// only while both banks still wait for replay. The back reads its bank one
// byte per cycle through the single RAM read port, unless rsp_tready holds
// the output back; a dropped query yields one empty item. Each rsp_ item
// carries up to eight reply bytes, first byte in the low bits, unused bytes
// zero; rsp_tlast marks the last item of a reply and rsp_tuser the outcome
// (0 A answer, 1 answer without data, 2 dropped with zero bytes). Queries
// shorter than the 12-byte header, longer than BUFFER_BYTES-16, with a
// compressed or reserved label, no root byte, or fewer than four bytes after
// it are dropped. Write portal_address (first octet in bits 31:24) through
// csr_ while no query is in progress.
// ============================================================================
module captive_dns_query_responder
   import cdqr_pkg::*;
#(
   parameter int BUFFER_BYTES = BUFFER_BYTES_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   // query bytes
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,    // [7:0] payload_byte
   input  logic        req_tlast,    // final_byte
   // reply words
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [71:0] rsp_tdata,    // [63:0] reply_word, [67:64] bytes_valid, rest zero
   output logic        rsp_tlast,    // reply_end
   output logic [1:0]  rsp_tuser,    // [1:0] reply_status
   // portal address register
   input  logic        csr_wr_en,
   input  logic [31:0] csr_wr_data
);

   localparam int CNT_W = $clog2(BUFFER_BYTES);

   logic [31:0] portal_address_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         portal_address_ff <= '0;
      end else if (csr_wr_en) begin
         portal_address_ff <= csr_wr_data;
      end
   end

   // buffer: two banks, bank select is the top address bit
   logic             ram_wr_en, ram_rd_en;
   logic [CNT_W:0]   ram_wr_addr, ram_rd_addr;
   logic [7:0]       ram_wr_data, ram_rd_data;

   logic             push, pop, head_valid;
   job_flags_type    push_flags, head_flags;
   logic [CNT_W-1:0] push_len, head_len;
   release_type      release_bank;

   cdqr_ram #(
      .WIDTH(8),
      .DEPTH(2 << CNT_W)
   ) u_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   cdqr_front #(
      .BUFFER_BYTES(BUFFER_BYTES),
      .CNT_W       (CNT_W)
   ) u_front (
      .clock        (clock),
      .reset        (reset),
      .req_tvalid   (req_tvalid),
      .req_tready   (req_tready),
      .req_tdata    (req_tdata),
      .req_tlast    (req_tlast),
      .ram_wr_en    (ram_wr_en),
      .ram_wr_addr  (ram_wr_addr),
      .ram_wr_data  (ram_wr_data),
      .push         (push),
      .push_flags   (push_flags),
      .push_len     (push_len),
      .release_bank (release_bank)
   );

   cdqr_queue #(
      .CNT_W(CNT_W)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_flags (push_flags),
      .push_len   (push_len),
      .pop        (pop),
      .head_valid (head_valid),
      .head_flags (head_flags),
      .head_len   (head_len)
   );

   cdqr_back #(
      .CNT_W(CNT_W)
   ) u_back (
      .clock          (clock),
      .reset          (reset),
      .portal_address (portal_address_ff),
      .head_valid     (head_valid),
      .head_flags     (head_flags),
      .head_len       (head_len),
      .pop            (pop),
      .release_bank   (release_bank),
      .ram_rd_en      (ram_rd_en),
      .ram_rd_addr    (ram_rd_addr),
      .ram_rd_data    (ram_rd_data),
      .rsp_tvalid     (rsp_tvalid),
      .rsp_tready     (rsp_tready),
      .rsp_tdata      (rsp_tdata),
      .rsp_tlast      (rsp_tlast),
      .rsp_tuser      (rsp_tuser)
   );

   // ---------------------------------------------------------------------
   // checks
   // ---------------------------------------------------------------------
   // a drop is a single empty item
   a_drop_empty : assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser == STATUS_DROP |-> rsp_tdata[67:64] == 4'd0 && rsp_tlast)
      else $error("drop item carries bytes or is not last");

   // only the last word of a reply may be short
   a_full_words : assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tlast |-> rsp_tdata[67:64] == 4'd8)
      else $error("short reply word before end of reply");

   // answered replies never carry an empty word
   a_word_nonempty : assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser != STATUS_DROP |->
         rsp_tdata[67:64] != 4'd0 && rsp_tdata[67:64] <= 4'd8)
      else $error("answer word byte count out of range");

   // the front never pushes the bank that the back releases in the same cycle
   a_bank_release : assert property (@(posedge clock) disable iff (reset)
      push && release_bank.valid |-> push_flags.bank != release_bank.bank)
      else $error("bank pushed and released in the same cycle");

endmodule
